// ===== hdl/sgf_pkg.sv =====
// Shared types and codes for the serial gap framer channel.
// Used by the front, queue and top modules; depends on nothing.
package sgf_pkg;

	typedef enum logic [2:0] {
		ACT_RX_BYTE  = 3'd0,
		ACT_TICK     = 3'd1,
		ACT_TX_LOAD  = 3'd2,
		ACT_TX_START = 3'd3,
		ACT_TX_EMPTY = 3'd4,
		ACT_TX_DONE  = 3'd5,
		ACT_RX_READ  = 3'd6,
		ACT_RX_REL   = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		RX_IDLE  = 2'd0,
		RX_RECV  = 2'd1,
		RX_READY = 2'd2
	} rx_phase_t;

	typedef enum logic [1:0] {
		TX_IDLE = 2'd0,
		TX_SEND = 2'd1,
		TX_DONE = 2'd2
	} tx_phase_t;

	localparam logic [1:0] CFG_RS485   = 2'd0;
	localparam logic [1:0] CFG_RX_GAP  = 2'd1;
	localparam logic [1:0] CFG_TX_TOUT = 2'd2;

	localparam logic [7:0] LIMIT_RESET = 8'd50;

	// Result queue between the front and the output side
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Status of one item after its action, before the store data joins it
	typedef struct packed {
		logic       send_valid;
		logic       rd_rx;
		logic [1:0] rx_state;
		logic [7:0] frame_length;
		logic [1:0] tx_state;
		logic       txe_irq_on;
		logic       line_drive;
		logic       frame_done;
	} stage_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic [7:0] read_byte;
		logic [1:0] rx_state;
		logic [7:0] frame_length;
		logic [1:0] tx_state;
		logic       txe_irq_on;
		logic       line_drive;
		logic       frame_done;
	} result_t;

	typedef struct packed {
		logic full;
		logic afull;
	} q_status_t;

endpackage

// ===== hdl/sgf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module sgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/sgf_front.sv =====
// Front part: configuration registers, receive/transmit control state and
// store port requests. Registers each accepted item's status for the queue.
// Depends on sgf_pkg.
module sgf_front #(
	parameter int RX_DEPTH = 256,
	parameter int TX_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        take,
	input  logic [2:0]                  action,
	input  logic [7:0]                  data_byte,
	input  logic [7:0]                  buf_index,
	input  logic [8:0]                  tx_count,
	output logic                        rx_we,
	output logic [$clog2(RX_DEPTH)-1:0] rx_waddr,
	output logic [$clog2(RX_DEPTH)-1:0] rx_raddr,
	output logic                        tx_we,
	output logic [$clog2(TX_DEPTH)-1:0] tx_waddr,
	output logic [$clog2(TX_DEPTH)-1:0] tx_raddr,
	output logic [7:0]                  wdata,
	output logic                        valid_s1,
	output sgf_pkg::stage_t             rec_s1
);
	import sgf_pkg::*;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	logic             rs485_q;
	logic [7:0]       rx_gap_q;
	logic [7:0]       tx_tout_q;

	rx_phase_t        rx_phase_q, rx_phase_n;
	logic [RX_AW-1:0] rx_fill_q, rx_fill_n, rx_fill_cur;
	logic [7:0]       rx_idle_q, rx_idle_n, rx_idle_inc;
	logic [7:0]       rx_len_q, rx_len_n;
	tx_phase_t        tx_phase_q, tx_phase_n;
	logic [8:0]       tx_pos_q, tx_pos_n, tx_pos_inc;
	logic [TX_AW-1:0] tx_addr_q, tx_addr_n, tx_addr_inc;
	logic [8:0]       tx_total_q, tx_total_n;
	logic [7:0]       tx_idle_q, tx_idle_n, tx_idle_inc;
	logic             txe_q, txe_n;
	logic             drive_q, drive_n;
	logic             send_n, rd_rx_n, done_n;

	logic [RX_AW-1:0] rx_idx_tab [256];
	logic [TX_AW-1:0] tx_idx_tab [256];

	// Index modulo depth, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_idx
		assign rx_idx_tab[g] = RX_AW'(g % RX_DEPTH);
		assign tx_idx_tab[g] = TX_AW'(g % TX_DEPTH);
	end

	assign rx_fill_cur = (rx_phase_q == RX_RECV) ? rx_fill_q : '0;
	assign rx_idle_inc = rx_idle_q + 8'd1;
	assign tx_idle_inc = tx_idle_q + 8'd1;
	assign tx_pos_inc  = tx_pos_q + 9'd1;
	assign tx_addr_inc = (tx_addr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_addr_q + TX_AW'(1);

	assign wdata    = data_byte;
	assign rx_waddr = rx_fill_cur;
	assign rx_raddr = rx_idx_tab[buf_index];
	assign tx_waddr = tx_idx_tab[buf_index];
	assign tx_raddr = (action_t'(action) == ACT_TX_START) ? '0 : tx_addr_inc;

	always_comb begin
		rx_phase_n = rx_phase_q;
		rx_fill_n  = rx_fill_q;
		rx_idle_n  = rx_idle_q;
		rx_len_n   = rx_len_q;
		tx_phase_n = tx_phase_q;
		tx_pos_n   = tx_pos_q;
		tx_addr_n  = tx_addr_q;
		tx_total_n = tx_total_q;
		tx_idle_n  = tx_idle_q;
		txe_n      = txe_q;
		drive_n    = drive_q;
		send_n     = 1'b0;
		rd_rx_n    = 1'b0;
		done_n     = 1'b0;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		case (action_t'(action))
			ACT_RX_BYTE: begin
				// drop the byte while a frame waits for release
				if (rx_phase_q != RX_READY) begin
					rx_phase_n = RX_RECV;
					rx_idle_n  = '0;
					rx_we      = take;
					rx_fill_n  = (rx_fill_cur == RX_AW'(RX_DEPTH - 1)) ? '0
						: rx_fill_cur + RX_AW'(1);
				end
			end
			ACT_TICK: begin
				if (rx_phase_q == RX_RECV) begin
					rx_idle_n = rx_idle_inc;
					if (rx_idle_inc >= rx_gap_q) begin
						rx_idle_n  = '0;
						rx_len_n   = 8'(rx_fill_q);
						rx_phase_n = RX_READY;
						done_n     = 1'b1;
					end
				end else begin
					rx_idle_n = '0;
				end
				if (tx_phase_q == TX_SEND) begin
					tx_idle_n = tx_idle_inc;
					if (tx_idle_inc >= tx_tout_q) begin
						tx_idle_n  = '0;
						tx_phase_n = TX_IDLE;
						txe_n      = 1'b0;
						if (rs485_q) begin
							drive_n = 1'b0;
						end
					end
				end else begin
					tx_idle_n = '0;
				end
			end
			ACT_TX_LOAD: begin
				tx_we = take;
			end
			ACT_TX_START: begin
				if (rs485_q) begin
					drive_n    = 1'b1;
					rx_phase_n = RX_IDLE;
					rx_fill_n  = '0;
					rx_idle_n  = '0;
				end
				tx_pos_n   = '0;
				tx_addr_n  = '0;
				tx_idle_n  = '0;
				tx_total_n = tx_count;
				tx_phase_n = TX_SEND;
				txe_n      = 1'b1;
				send_n     = 1'b1;
			end
			ACT_TX_EMPTY: begin
				if (txe_q) begin
					tx_idle_n = '0;
					tx_pos_n  = tx_pos_inc;
					tx_addr_n = tx_addr_inc;
					if (tx_pos_inc < tx_total_q) begin
						send_n = 1'b1;
					end else begin
						txe_n = 1'b0;
					end
				end
			end
			ACT_TX_DONE: begin
				if (rs485_q) begin
					drive_n = 1'b0;
				end
				tx_phase_n = TX_DONE;
				tx_idle_n  = '0;
			end
			ACT_RX_READ: begin
				rd_rx_n = 1'b1;
			end
			ACT_RX_REL: begin
				rx_phase_n = RX_IDLE;
				rx_fill_n  = '0;
				rx_idle_n  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs485_q    <= 1'b0;
			rx_gap_q   <= LIMIT_RESET;
			tx_tout_q  <= LIMIT_RESET;
			rx_phase_q <= RX_IDLE;
			rx_fill_q  <= '0;
			rx_idle_q  <= '0;
			rx_len_q   <= '0;
			tx_phase_q <= TX_IDLE;
			tx_pos_q   <= '0;
			tx_addr_q  <= '0;
			tx_total_q <= '0;
			tx_idle_q  <= '0;
			txe_q      <= 1'b0;
			drive_q    <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RS485:   rs485_q   <= cfg_data[0];
					CFG_RX_GAP:  rx_gap_q  <= cfg_data;
					CFG_TX_TOUT: tx_tout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			valid_s1 <= take;
			if (take) begin
				rx_phase_q <= rx_phase_n;
				rx_fill_q  <= rx_fill_n;
				rx_idle_q  <= rx_idle_n;
				rx_len_q   <= rx_len_n;
				tx_phase_q <= tx_phase_n;
				tx_pos_q   <= tx_pos_n;
				tx_addr_q  <= tx_addr_n;
				tx_total_q <= tx_total_n;
				tx_idle_q  <= tx_idle_n;
				txe_q      <= txe_n;
				drive_q    <= drive_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_s1.send_valid   <= send_n;
			rec_s1.rd_rx        <= rd_rx_n;
			rec_s1.rx_state     <= rx_phase_n;
			rec_s1.frame_length <= rx_len_n;
			rec_s1.tx_state     <= tx_phase_n;
			rec_s1.txe_irq_on   <= txe_n;
			rec_s1.line_drive   <= drive_n;
			rec_s1.frame_done   <= done_n;
		end
	end

endmodule

// ===== hdl/sgf_queue.sv =====
// Back part: short result queue that drives the output channel.
// Depends on sgf_pkg.
module sgf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sgf_pkg::result_t   push_data,
	output sgf_pkg::q_status_t status,
	output logic               out_valid,
	input  logic               out_stall,
	output sgf_pkg::result_t   head
);
	import sgf_pkg::*;

	result_t          slot_q [QDEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QAW:0]     count_q;
	logic             pop;

	assign out_valid    = (count_q != '0);
	assign pop          = out_valid && !out_stall;
	assign head         = slot_q[rd_q];
	assign status.full  = (count_q == (QAW+1)'(QDEPTH));
	assign status.afull = (count_q >= (QAW+1)'(QDEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/serial_gap_framer_channel.sv =====
// Top level of the serial gap framer channel: front control, two buffer RAMs
// and the result queue. Depends on sgf_pkg, sgf_ram, sgf_front, sgf_queue.
//
//   channel   handshake           payload
//   input     in_valid/in_stall   action, data_byte, buf_index, tx_count
//   output    out_valid/out_stall send_valid .. frame_done (one per input)
//   config    cfg_we              cfg_index, cfg_data
//
// One item per clock while in_stall is low; each result passes the state update and
// RAM read register and then the queue on its way to the output. Reset clears control
// state; buffer contents are left as is.
// in_stall rises when the four-entry queue cannot take the item in flight plus one.
module serial_gap_framer_channel #(
	parameter int RX_DEPTH = 256,
	parameter int TX_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [7:0] data_byte,
	input  logic [7:0] buf_index,
	input  logic [8:0] tx_count,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       send_valid,
	output logic [7:0] send_byte,
	output logic [7:0] read_byte,
	output logic [1:0] rx_state,
	output logic [7:0] frame_length,
	output logic [1:0] tx_state,
	output logic       txe_irq_on,
	output logic       line_drive,
	output logic       frame_done
);
	import sgf_pkg::*;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	logic             take;
	logic             rx_we, tx_we;
	logic [RX_AW-1:0] rx_waddr, rx_raddr;
	logic [TX_AW-1:0] tx_waddr, tx_raddr;
	logic [7:0]       wdata, rx_rdata, tx_rdata;
	logic             valid_s1;
	stage_t           rec_s1;
	result_t          res_s1, head;
	q_status_t        q_status;

	assign in_stall = q_status.full || (q_status.afull && valid_s1);
	assign take     = in_valid && !in_stall;

	sgf_front #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.action    (action),
		.data_byte (data_byte),
		.buf_index (buf_index),
		.tx_count  (tx_count),
		.rx_we     (rx_we),
		.rx_waddr  (rx_waddr),
		.rx_raddr  (rx_raddr),
		.tx_we     (tx_we),
		.tx_waddr  (tx_waddr),
		.tx_raddr  (tx_raddr),
		.wdata     (wdata),
		.valid_s1  (valid_s1),
		.rec_s1    (rec_s1)
	);

	sgf_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (wdata),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	sgf_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (wdata),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	// Join the status with the byte read from the buffer
	always_comb begin
		res_s1.send_valid   = rec_s1.send_valid;
		res_s1.send_byte    = rec_s1.send_valid ? tx_rdata : 8'd0;
		res_s1.read_byte    = rec_s1.rd_rx ? rx_rdata : 8'd0;
		res_s1.rx_state     = rec_s1.rx_state;
		res_s1.frame_length = rec_s1.frame_length;
		res_s1.tx_state     = rec_s1.tx_state;
		res_s1.txe_irq_on   = rec_s1.txe_irq_on;
		res_s1.line_drive   = rec_s1.line_drive;
		res_s1.frame_done   = rec_s1.frame_done;
	end

	sgf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res_s1),
		.status    (q_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign send_valid   = head.send_valid;
	assign send_byte    = head.send_byte;
	assign read_byte    = head.read_byte;
	assign rx_state     = head.rx_state;
	assign frame_length = head.frame_length;
	assign tx_state     = head.tx_state;
	assign txe_irq_on   = head.txe_irq_on;
	assign line_drive   = head.line_drive;
	assign frame_done   = head.frame_done;

endmodule
